// ----- rtl/iqla_pkg.sv -----
package iqla_pkg;

  // field widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned EcgW      = 12;
  localparam int unsigned AccW      = 32;
  localparam int unsigned EcgSumW   = 22;
  localparam int unsigned FrameNumW = 8;
  localparam int unsigned FrameLenW = 11;

  // mid-scale code of the offset binary converters
  localparam logic [SampleW-1:0] MidCode = 16'd32767;

  // frame length after reset
  localparam logic [FrameLenW-1:0] FrameLenReset = 11'd1024;

  // shortest frame
  localparam logic [FrameLenW-1:0] MinFrameLen = 11'd2;

  typedef logic [SampleW-1:0]          code_t;
  typedef logic signed [SampleW-1:0]   cval_t;
  typedef logic [EcgW-1:0]             ecg_t;
  typedef logic signed [AccW-1:0]      acc_t;
  typedef logic [EcgSumW-1:0]          ecg_sum_t;
  typedef logic [FrameNumW-1:0]        frame_num_t;
  typedef logic [FrameLenW-1:0]        frame_len_t;

  // offset binary code to signed, keeping the low 16 bits
  function automatic cval_t center(input code_t code);
    code_t diff;
    diff = code - MidCode;
    return cval_t'(diff);
  endfunction

endpackage

// ----- rtl/iqla_in_if.sv -----
interface iqla_in_if import iqla_pkg::*; ();

  logic  valid;
  logic  ready;
  code_t sample_a;
  code_t sample_b;
  code_t sample_c;
  ecg_t  sample_ecg;
  cval_t ref_sin;
  cval_t ref_cos;

  modport source (
    output valid, sample_a, sample_b, sample_c, sample_ecg, ref_sin, ref_cos,
    input  ready
  );

  modport sink (
    input  valid, sample_a, sample_b, sample_c, sample_ecg, ref_sin, ref_cos,
    output ready
  );

endinterface

// ----- rtl/iqla_out_if.sv -----
interface iqla_out_if import iqla_pkg::*; ();

  logic       valid;
  logic       ready;
  acc_t       a_in_phase;
  acc_t       a_quadrature;
  acc_t       b_in_phase;
  acc_t       b_quadrature;
  acc_t       c_in_phase;
  acc_t       c_quadrature;
  ecg_sum_t   ecg_total;
  frame_num_t frame_number;

  modport source (
    output valid, a_in_phase, a_quadrature, b_in_phase, b_quadrature,
           c_in_phase, c_quadrature, ecg_total, frame_number,
    input  ready
  );

  modport sink (
    input  valid, a_in_phase, a_quadrature, b_in_phase, b_quadrature,
           c_in_phase, c_quadrature, ecg_total, frame_number,
    output ready
  );

endinterface

// ----- rtl/iqla_prod.sv -----
module iqla_prod import iqla_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  cval_t x_i,
  input  cval_t sin_i,
  input  cval_t cos_i,
  output acc_t  p_sin_o,
  output acc_t  p_cos_o
);

  acc_t p_sin_q, p_sin_d;
  acc_t p_cos_q, p_cos_d;

  // in-phase and quadrature products, exact in 32 bits
  always_comb begin
    p_sin_d = acc_t'(x_i) * acc_t'(sin_i);
    p_cos_d = acc_t'(x_i) * acc_t'(cos_i);
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_sin_q <= p_sin_d;
      p_cos_q <= p_cos_d;
    end
  end

  assign p_sin_o = p_sin_q;
  assign p_cos_o = p_cos_q;

endmodule

// ----- rtl/iq_lock_in_accumulator_top.sv -----
// Path: a result word is registered once the sample word that closes its frame has passed
// the input register, the product register, then the accumulator and result register.
// Throughput: one sample word per cycle; a result waiting at the output holds the pipe
// only while it is not taken, set by the single result register.
// Reset (rst_ni low, asynchronous): sums, sample count and frame number clear to zero,
// frame length returns to 1024, pipeline and output empty.
module iq_lock_in_accumulator_top import iqla_pkg::*; #(
  parameter int unsigned MaxFrame = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  frame_len_t cfg_wdata_i,
  iqla_in_if.sink    in_i,
  iqla_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(MaxFrame + 1);
  localparam int unsigned LenW = (CntW > FrameLenW) ? CntW : FrameLenW;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned NumSums = 2 * NumLanes;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [LenW-1:0] len_t;

  logic       adv;
  frame_len_t frame_len_q;

  // input register
  logic  v1_q;
  cval_t x1_q [NumLanes];
  cval_t sin1_q, cos1_q;
  ecg_t  ecg1_q;

  // product register
  logic  v2_q;
  ecg_t  ecg2_q;
  acc_t  prod [NumSums];

  // accumulator
  acc_t       sums_q [NumSums];
  acc_t       sums_d [NumSums];
  ecg_sum_t   ecg_q, ecg_d;
  cnt_t       cnt_q;
  len_t       eff_len;
  len_t       cnt_next;
  logic       close;
  frame_num_t frame_q, frame_d;

  // result register
  logic       out_valid_q;
  acc_t       res_q [NumSums];
  ecg_sum_t   res_ecg_q;
  frame_num_t res_frame_q;

  // whole pipe moves unless a result is stuck at the output
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  // frame length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= FrameLenReset;
    end else if (cfg_we_i) begin
      frame_len_q <= cfg_wdata_i;
    end
  end

  // input register, codes centered on the way in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_i.valid) begin
      x1_q[0] <= center(in_i.sample_a);
      x1_q[1] <= center(in_i.sample_b);
      x1_q[2] <= center(in_i.sample_c);
      sin1_q  <= in_i.ref_sin;
      cos1_q  <= in_i.ref_cos;
      ecg1_q  <= in_i.sample_ecg;
    end
  end

  // one product pair per channel
  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    iqla_prod u_prod (
      .clk_i   (clk_i),
      .en_i    (adv),
      .x_i     (x1_q[k]),
      .sin_i   (sin1_q),
      .cos_i   (cos1_q),
      .p_sin_o (prod[2*k]),
      .p_cos_o (prod[2*k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ecg2_q <= ecg1_q;
    end
  end

  // frame length in effect, clamped to the supported range
  always_comb begin
    eff_len = len_t'(frame_len_q);
    if (eff_len < len_t'(MinFrameLen)) begin
      eff_len = len_t'(MinFrameLen);
    end
    if (eff_len > len_t'(MaxFrame)) begin
      eff_len = len_t'(MaxFrame);
    end
  end

  // sums including this sample, and end of frame test
  always_comb begin
    for (int k = 0; k < NumSums; k++) begin
      sums_d[k] = sums_q[k] + prod[k];
    end
    ecg_d    = ecg_q + ecg_sum_t'(ecg2_q);
    cnt_next = len_t'(cnt_q) + len_t'(1);
    close    = cnt_next >= eff_len;
    frame_d  = frame_q + frame_num_t'(1);
  end

  // accumulators, sample count and frame number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSums; k++) begin
        sums_q[k] <= '0;
      end
      ecg_q   <= '0;
      cnt_q   <= '0;
      frame_q <= '0;
    end else if (adv && v2_q) begin
      if (close) begin
        for (int k = 0; k < NumSums; k++) begin
          sums_q[k] <= '0;
        end
        ecg_q   <= '0;
        cnt_q   <= '0;
        frame_q <= frame_d;
      end else begin
        for (int k = 0; k < NumSums; k++) begin
          sums_q[k] <= sums_d[k];
        end
        ecg_q <= ecg_d;
        cnt_q <= cnt_next[CntW-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q && close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && v2_q && close) begin
      for (int k = 0; k < NumSums; k++) begin
        res_q[k] <= sums_d[k];
      end
      res_ecg_q   <= ecg_d;
      res_frame_q <= frame_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.a_in_phase   = res_q[0];
  assign out_o.a_quadrature = res_q[1];
  assign out_o.b_in_phase   = res_q[2];
  assign out_o.b_quadrature = res_q[3];
  assign out_o.c_in_phase   = res_q[4];
  assign out_o.c_quadrature = res_q[5];
  assign out_o.ecg_total    = res_ecg_q;
  assign out_o.frame_number = res_frame_q;

  // sample count always stays below the longest frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < cnt_t'(MaxFrame))
    else $error("sample count reached the frame limit");

  // a new result only comes from a product stage word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v2_q))
    else $error("result without a sample behind it");

  // closing a frame restarts the count and shows a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v2_q && close) |=> (cnt_q == '0) && out_valid_q)
    else $error("frame close did not restart the count");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import iqla_pkg::*;

  localparam int unsigned MaxFrame     = 1024;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned StallCycles  = 400;
  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned ShowLimit    = 10;

  // one sample word
  typedef struct packed {
    code_t a;
    code_t b;
    code_t c;
    ecg_t  ecg;
    cval_t sin;
    cval_t cos;
  } sample_t;

  // one frame result word
  typedef struct packed {
    acc_t       a_in_phase;
    acc_t       a_quadrature;
    acc_t       b_in_phase;
    acc_t       b_quadrature;
    acc_t       c_in_phase;
    acc_t       c_quadrature;
    ecg_sum_t   ecg_total;
    frame_num_t frame_number;
  } result_t;

  // directed row: optional length write before the word, optional typed frame
  typedef struct packed {
    logic       set_len;
    frame_len_t len;
    sample_t    smp;
    logic       typed;
    result_t    want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  frame_len_t cfg_wdata;

  iqla_in_if  in_if ();
  iqla_out_if out_if ();

  iq_lock_in_accumulator_top #(
    .MaxFrame (MaxFrame)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // accumulator model state
  acc_t       acc_sums [6];
  ecg_sum_t   acc_ecg;
  int         acc_count;
  frame_num_t acc_frame;
  frame_len_t acc_len;

  result_t pending_frames [$];
  dir_row_t dir_rows [$];

  int errors          = 0;
  int frames_checked  = 0;
  int samples_sent    = 0;
  int length_writes   = 0;
  int cycle_count     = 0;
  int src_idle        = 0;
  int snk_idle        = 0;
  int stall_seq       = 0;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= ShowLimit) begin
      $display("%s", msg);
    end
  endfunction

  // fold one sample into the frame sums, report the frame when it closes
  task automatic accumulate_sample(input sample_t s, output bit closed, output result_t r);
    code_t codes [3];
    cval_t chan;
    frame_len_t span;
    closed = 1'b0;
    r = '0;
    codes[0] = s.a;
    codes[1] = s.b;
    codes[2] = s.c;
    for (int k = 0; k < 3; k++) begin
      chan = cval_t'(code_t'(codes[k] - MidCode));
      acc_sums[2 * k]     += acc_t'(chan) * acc_t'(s.sin);
      acc_sums[2 * k + 1] += acc_t'(chan) * acc_t'(s.cos);
    end
    acc_ecg = acc_ecg + ecg_sum_t'(s.ecg);
    acc_count++;
    // length in effect is clamped to 2..MaxFrame
    span = acc_len;
    if (span < MinFrameLen) begin
      span = MinFrameLen;
    end
    if (span > frame_len_t'(MaxFrame)) begin
      span = frame_len_t'(MaxFrame);
    end
    if (acc_count >= int'(span)) begin
      acc_frame++;
      r.a_in_phase   = acc_sums[0];
      r.a_quadrature = acc_sums[1];
      r.b_in_phase   = acc_sums[2];
      r.b_quadrature = acc_sums[3];
      r.c_in_phase   = acc_sums[4];
      r.c_quadrature = acc_sums[5];
      r.ecg_total    = acc_ecg;
      r.frame_number = acc_frame;
      for (int k = 0; k < 6; k++) begin
        acc_sums[k] = '0;
      end
      acc_ecg   = '0;
      acc_count = 0;
      closed    = 1'b1;
    end
  endtask

  function automatic code_t rand_code();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return MidCode;
      3: return MidCode + 16'd1;
      default: return code_t'($urandom_range(65535));
    endcase
  endfunction

  function automatic cval_t rand_ref();
    case ($urandom_range(7))
      0: return cval_t'(16'h8000);
      1: return cval_t'(16'h7fff);
      2: return '0;
      default: return cval_t'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.a   = rand_code();
    s.b   = rand_code();
    s.c   = rand_code();
    case ($urandom_range(5))
      0: s.ecg = '0;
      1: s.ecg = '1;
      default: s.ecg = ecg_t'($urandom_range(4095));
    endcase
    s.sin = rand_ref();
    s.cos = rand_ref();
    return s;
  endfunction

  function automatic dir_row_t make_row(input bit set, input int len, input int a, input int b,
                                        input int c, input int e, input int s, input int co);
    dir_row_t r;
    r         = '0;
    r.set_len = set;
    r.len     = frame_len_t'(len);
    r.smp.a   = code_t'(a);
    r.smp.b   = code_t'(b);
    r.smp.c   = code_t'(c);
    r.smp.ecg = ecg_t'(e);
    r.smp.sin = cval_t'(s);
    r.smp.cos = cval_t'(co);
    return r;
  endfunction

  // offer one sample word, hold it until taken, then log its frame if it closes one
  task automatic send_sample(input sample_t s, input bit typed, input result_t want);
    bit closed;
    bit taken;
    result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.sample_a   <= s.a;
    in_if.sample_b   <= s.b;
    in_if.sample_c   <= s.c;
    in_if.sample_ecg <= s.ecg;
    in_if.ref_sin    <= s.sin;
    in_if.ref_cos    <= s.cos;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_if.valid && in_if.ready;
    end
    accumulate_sample(s, closed, r);
    if (typed) begin
      pending_frames.push_back(want);
    end else if (closed) begin
      pending_frames.push_back(r);
    end
    samples_sent++;
  endtask

  // stop offering, wait for every frame due, let the pipe settle
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_frames.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_length(input frame_len_t len);
    drain();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    acc_len = len;
    length_writes++;
  endtask

  // receiver: random ready, with a long hold-off on request
  initial begin : sink_drive
    int hold_left;
    int stall_seen;
    hold_left    = 0;
    stall_seen   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_seen != stall_seq) begin
        stall_seen = stall_seq;
        hold_left  = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] got,
                                      input logic [31:0] want, input frame_num_t frame);
    if (got !== want) begin
      note_error($sformatf("frame %0d %s mismatch: expected 'h%08h got 'h%08h",
                           frame, name, want, got));
    end
  endfunction

  // compare each result word with the oldest frame due
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_frames.size() == 0) begin
        note_error($sformatf("unexpected result word, frame number %0d", out_if.frame_number));
      end else begin
        want = pending_frames.pop_front();
        check_field("a_in_phase", out_if.a_in_phase, want.a_in_phase, want.frame_number);
        check_field("a_quadrature", out_if.a_quadrature, want.a_quadrature,
                    want.frame_number);
        check_field("b_in_phase", out_if.b_in_phase, want.b_in_phase, want.frame_number);
        check_field("b_quadrature", out_if.b_quadrature, want.b_quadrature,
                    want.frame_number);
        check_field("c_in_phase", out_if.c_in_phase, want.c_in_phase, want.frame_number);
        check_field("c_quadrature", out_if.c_quadrature, want.c_quadrature,
                    want.frame_number);
        check_field("ecg_total", 32'(out_if.ecg_total), 32'(want.ecg_total),
                    want.frame_number);
        check_field("frame_number", 32'(out_if.frame_number), 32'(want.frame_number),
                    want.frame_number);
        frames_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d frames still due", cycle_count,
               pending_frames.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int len;
    int n;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.sample_a   = '0;
    in_if.sample_b   = '0;
    in_if.sample_c   = '0;
    in_if.sample_ecg = '0;
    in_if.ref_sin    = '0;
    in_if.ref_cos    = '0;
    for (int k = 0; k < 6; k++) begin
      acc_sums[k] = '0;
    end
    acc_ecg   = '0;
    acc_count = 0;
    acc_frame = '0;
    acc_len   = FrameLenReset;

    // directed table
    // partial frame at the reset length, then a shorter length closes it at once
    dir_rows.push_back(make_row(0, 0, 32767, 32767, 32767, 4095, 32767, -32768));
    dir_rows.push_back(make_row(0, 0, 0, 0, 0, 0, -32768, 32767));
    dir_rows.push_back(make_row(0, 0, 65535, 65535, 65535, 2048, 12345, -12345));
    dir_rows.push_back(make_row(1, 2, 32768, 1, 40000, 77, -1, 1));
    // mid codes give zero sums
    dir_rows.push_back(make_row(0, 0, 32767, 32767, 32767, 4095, 32767, -32768));
    dir_rows.push_back(make_row(0, 0, 32767, 32767, 32767, 4095, 32767, -32768));
    // most negative code times most negative reference wraps the sum
    dir_rows.push_back(make_row(0, 0, 65535, 65535, 65535, 0, -32768, 32767));
    dir_rows.push_back(make_row(0, 0, 65535, 65535, 65535, 0, -32768, 32767));
    // length 0 acts as 2, code 0 is -32767
    dir_rows.push_back(make_row(1, 0, 0, 0, 0, 1, 32767, 0));
    dir_rows.push_back(make_row(0, 0, 0, 0, 0, 1, 32767, 0));
    // length 1 acts as 2
    dir_rows.push_back(make_row(1, 1, 1, 65534, 32766, 4095, 32767, 32767));
    dir_rows.push_back(make_row(0, 0, 50000, 10000, 20000, 1234, -32768, -32768));
    dir_rows.push_back(make_row(1, 3, 43690, 21845, 65535, 2730, 21845, -21846));
    dir_rows.push_back(make_row(0, 0, 255, 65280, 3855, 1365, -256, 255));
    dir_rows.push_back(make_row(0, 0, 61680, 0, 32767, 4000, 100, -100));
    // length above the top acts as the top, then 1024, then 5 closes the running frame
    dir_rows.push_back(make_row(1, 2047, 11111, 22222, 33333, 10, 5000, -5000));
    dir_rows.push_back(make_row(0, 0, 44444, 55555, 6666, 20, -7000, 7000));
    dir_rows.push_back(make_row(0, 0, 7777, 8888, 9999, 30, 32767, -32768));
    dir_rows.push_back(make_row(1, 1024, 65535, 0, 32768, 40, -32768, -32768));
    dir_rows.push_back(make_row(0, 0, 0, 65535, 1, 50, 32767, 32767));
    dir_rows.push_back(make_row(1, 5, 30000, 35000, 32767, 60, -1, -1));
    dir_rows.push_back(make_row(0, 0, 1, 2, 3, 4095, 1, 2));
    dir_rows.push_back(make_row(0, 0, 65533, 65534, 65535, 4094, -2, -3));
    dir_rows.push_back(make_row(0, 0, 32000, 33000, 34000, 2000, 16384, -16384));
    dir_rows.push_back(make_row(0, 0, 100, 200, 300, 3000, 8192, -8192));
    dir_rows[5].typed = 1'b1;
    dir_rows[5].want  = '{a_in_phase: 32'sd0, a_quadrature: 32'sd0,
                          b_in_phase: 32'sd0, b_quadrature: 32'sd0,
                          c_in_phase: 32'sd0, c_quadrature: 32'sd0,
                          ecg_total: 22'd8190, frame_number: 8'd2};
    dir_rows[7].typed = 1'b1;
    dir_rows[7].want  = '{a_in_phase: 32'h8000_0000, a_quadrature: 32'h8001_0000,
                          b_in_phase: 32'h8000_0000, b_quadrature: 32'h8001_0000,
                          c_in_phase: 32'h8000_0000, c_quadrature: 32'h8001_0000,
                          ecg_total: 22'd0, frame_number: 8'd3};
    dir_rows[9].typed = 1'b1;
    dir_rows[9].want  = '{a_in_phase: 32'h8001_fffe, a_quadrature: 32'sd0,
                          b_in_phase: 32'h8001_fffe, b_quadrature: 32'sd0,
                          c_in_phase: 32'h8001_fffe, c_quadrature: 32'sd0,
                          ecg_total: 22'd2, frame_number: 8'd4};

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    src_idle = 9;
    snk_idle = 86;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_len) begin
        set_length(dir_rows[i].len);
      end
      send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: segments of random length, written between segments so frames
    // are often cut short or stretched while partly summed
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle = 9;
          snk_idle = 86;
        end
        1: begin
          src_idle = 86;
          snk_idle = 9;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      for (int seg = 0; seg < 10; seg++) begin
        case ($urandom_range(9))
          0: len = $urandom_range(1);
          1: len = $urandom_range(64, 17);
          default: len = $urandom_range(12, 2);
        endcase
        set_length(frame_len_t'(len));
        n = $urandom_range(35, 5);
        repeat (n) send_sample(rand_sample(), 1'b0, '0);
      end
    end

    // long receiver hold-off with the shortest frames, so the pipe backs up
    set_length(MinFrameLen);
    stall_seq++;
    repeat (30) send_sample(rand_sample(), 1'b0, '0);

    drain();

    $display("covered %0d sample words and %0d checked frames over %0d length writes",
             samples_sent, frames_checked, length_writes);
    $display("with both sides throttled each way, out of range lengths and a long stall");
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
